// ===== rtl/core/xoshiro256ss_uniform_range_unit_assert.svh =====
`ifndef XOSHIRO256SS_UNIFORM_RANGE_UNIT_ASSERT_SVH
`define XOSHIRO256SS_UNIFORM_RANGE_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define XRS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define XRS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/xrs_pkg.sv =====
package xrs_pkg;

	localparam int unsigned XRS_MID_DEPTH = 4;
	localparam int unsigned XRS_OUT_DEPTH = 16;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned SEED_COUNT  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_SEED_WORD0 = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_WORD3 = CFG_INDEX_W'(3);

	localparam logic [63:0] SEED0_RESET = 64'd1;
	localparam logic [63:0] SEEDN_RESET = 64'd0;

	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [63:0]        word1;
		logic signed [31:0] lower;
		logic signed [31:0] upper;
	} mid_entry_t;

	typedef struct packed {
		logic signed [31:0] ranged;
		logic [63:0]        raw;
	} result_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
		return (v << r) | (v >> (64 - r));
	endfunction

endpackage

// ===== rtl/core/xrs_fifo.sv =====
module xrs_fifo
	import xrs_pkg::*;
#(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/xrs_front.sv =====
module xrs_front
	import xrs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_wdata,
	input  logic                   accept,
	input  logic signed [31:0]     lower_bound,
	input  logic signed [31:0]     upper_bound,
	output mid_entry_t             entry
);

	logic [63:0] seed_q [SEED_COUNT];
	logic [63:0] gen_q  [SEED_COUNT];
	logic [63:0] gen_next [SEED_COUNT];
	logic [63:0] x20;
	logic [63:0] x31;
	logic        cfg_hit;

	// The output word comes from generator word one before the update, so the
	// back end only needs that word to finish the draw.
	assign entry.word1 = gen_q[1];
	assign entry.lower = lower_bound;
	assign entry.upper = upper_bound;

	assign cfg_hit = cfg_we && (cfg_index <= REG_SEED_WORD3);

	always_comb begin
		x20 = gen_q[2] ^ gen_q[0];
		x31 = gen_q[3] ^ gen_q[1];
		gen_next[0] = gen_q[0] ^ x31;
		gen_next[1] = gen_q[1] ^ x20;
		gen_next[2] = x20 ^ (gen_q[1] << 17);
		gen_next[3] = rotl64(x31, 45);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q[0] <= SEED0_RESET;
			gen_q[0]  <= SEED0_RESET;
			for (int i = 1; i < SEED_COUNT; i++) begin
				seed_q[i] <= SEEDN_RESET;
				gen_q[i]  <= SEEDN_RESET;
			end
		end else if (cfg_hit) begin
			// Any seed write reloads all four generator words.
			for (int i = 0; i < SEED_COUNT; i++) begin
				if (cfg_index == REG_SEED_WORD0 + CFG_INDEX_W'(i)) begin
					seed_q[i] <= cfg_wdata;
					gen_q[i]  <= cfg_wdata;
				end else begin
					gen_q[i]  <= seed_q[i];
				end
			end
		end else if (accept) begin
			for (int i = 0; i < SEED_COUNT; i++) begin
				gen_q[i] <= gen_next[i];
			end
		end
	end

endmodule

// ===== rtl/core/xrs_back.sv =====
`include "xoshiro256ss_uniform_range_unit_assert.svh"

module xrs_back
	import xrs_pkg::*;
#(
	parameter int unsigned OUT_DEPTH = XRS_OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mid_entry_t mid_head,
	input  logic       mid_empty,
	output logic       mid_pop,
	input  logic       out_full,
	output logic       out_push,
	output result_t    out_data,
	input  logic       out_pop_done
);

	localparam int unsigned CRED_W = $clog2(OUT_DEPTH + 1);

	logic [CRED_W-1:0] slots_q;
	logic              issue;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [6:0] valid_vec;

	logic [63:0] w5;
	logic [33:0] spread;

	logic [63:0] w5r_s1;
	logic [31:0] lo_s1, hi_s1;
	logic        neg_s1;
	logic [32:0] abs_s1;

	logic [63:0] raw_s2;
	logic [31:0] lo_s2, hi_s2;
	logic        neg_s2;
	logic [32:0] abs_s2;

	logic [31:0] top;
	logic [31:0] top_neg;
	logic [30:0] mag;

	logic [63:0] raw_s3;
	logic [31:0] lo_s3, hi_s3;
	logic        neg_s3;
	logic [32:0] abs_s3;
	logic [30:0] mag_s3;
	logic        full_s3;

	logic [63:0] raw_s4;
	logic [31:0] lo_s4, hi_s4;
	logic        neg_s4, full_s4;
	logic [63:0] prod_s4;

	logic [63:0] raw_s5;
	logic [31:0] lo_s5, hi_s5;
	logic        neg_s5, full_s5;
	logic [32:0] r0_s5;
	logic [31:0] qa_s5;

	logic [1:0]  a1;
	logic [31:0] r1;

	logic [63:0] raw_s6;
	logic [31:0] lo_s6, hi_s6;
	logic        neg_s6, full_s6;
	logic [31:0] q_s6;
	logic        ge_s6, nz_s6;

	logic [31:0] qf;
	logic [31:0] res;

	result_t     res_s7;

	// Items are issued only against free output-queue slots, so the pipeline
	// never has to stall.
	assign issue    = !mid_empty && (slots_q < CRED_W'(OUT_DEPTH));
	assign mid_pop  = issue;
	assign out_push = valid_s7;
	assign out_data = res_s7;
	assign valid_vec = {valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (issue && !out_pop_done) begin
				slots_q <= slots_q + CRED_W'(1);
			end else if (out_pop_done && !issue) begin
				slots_q <= slots_q - CRED_W'(1);
			end
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_comb begin
		w5     = mid_head.word1 + {mid_head.word1[61:0], 2'b00};
		spread = {{2{mid_head.upper[31]}}, mid_head.upper}
			- {{2{mid_head.lower[31]}}, mid_head.lower} + 34'd1;
	end

	always_comb begin
		top     = raw_s2[63:32];
		top_neg = ~top + 32'd1;
		if (!top[31]) begin
			mag = top[30:0];
		end else if (top == 32'h8000_0000) begin
			mag = MAG_MAX;
		end else begin
			mag = top_neg[30:0];
		end
	end

	always_comb begin
		a1 = r0_s5[32:31];
		r1 = {30'd0, a1} + {1'b0, r0_s5[30:0]};
	end

	// Negative products round toward minus infinity: one more step down
	// whenever the division leaves a remainder.
	always_comb begin
		qf = q_s6 + {31'd0, ge_s6} + {31'd0, neg_s6 & nz_s6};
		if (full_s6) begin
			res = hi_s6;
		end else if (neg_s6) begin
			res = lo_s6 - qf;
		end else begin
			res = lo_s6 + qf;
		end
	end

	always_ff @(posedge clk) begin
		w5r_s1 <= rotl64(w5, 7);
		lo_s1  <= mid_head.lower;
		hi_s1  <= mid_head.upper;
		neg_s1 <= spread[33];
		abs_s1 <= spread[33] ? 33'(~spread + 34'd1) : spread[32:0];

		raw_s2 <= w5r_s1 + {w5r_s1[60:0], 3'b000};
		lo_s2  <= lo_s1;
		hi_s2  <= hi_s1;
		neg_s2 <= neg_s1;
		abs_s2 <= abs_s1;

		raw_s3  <= raw_s2;
		lo_s3   <= lo_s2;
		hi_s3   <= hi_s2;
		neg_s3  <= neg_s2;
		abs_s3  <= abs_s2;
		mag_s3  <= mag;
		full_s3 <= (mag == MAG_MAX);

		raw_s4  <= raw_s3;
		lo_s4   <= lo_s3;
		hi_s4   <= hi_s3;
		neg_s4  <= neg_s3;
		full_s4 <= full_s3;
		prod_s4 <= {33'd0, mag_s3} * {31'd0, abs_s3};

		// Division by 2^31-1: the high part is a first quotient and folds back
		// into the remainder, which then needs one more fold and one compare.
		raw_s5  <= raw_s4;
		lo_s5   <= lo_s4;
		hi_s5   <= hi_s4;
		neg_s5  <= neg_s4;
		full_s5 <= full_s4;
		r0_s5   <= prod_s4[63:31] + {2'b00, prod_s4[30:0]};
		qa_s5   <= prod_s4[62:31];

		raw_s6  <= raw_s5;
		lo_s6   <= lo_s5;
		hi_s6   <= hi_s5;
		neg_s6  <= neg_s5;
		full_s6 <= full_s5;
		q_s6    <= qa_s5 + {30'd0, a1};
		ge_s6   <= (r1 >= {1'b0, MAG_MAX});
		nz_s6   <= (r1 != 32'd0) && (r1 != {1'b0, MAG_MAX});

		res_s7.ranged <= res;
		res_s7.raw    <= raw_s6;
	end

	`XRS_CHECK(a_slots_bound, slots_q <= CRED_W'(OUT_DEPTH), "output credit above queue depth")
	`XRS_CHECK(a_no_overflow, !out_push || !out_full, "result written into a full output queue")
	`XRS_CHECK(a_inflight_covered, $countones(valid_vec) <= slots_q, "in-flight items exceed credit")
	`XRS_CHECK_NEXT(a_no_issue_when_full, slots_q == CRED_W'(OUT_DEPTH), !valid_s1,
		"item issued without a free output slot")

endmodule

// ===== rtl/core/xoshiro256ss_uniform_range_unit.sv =====
// Uniform range source built on a xoshiro256** generator.
// Input queue side: drive lower_bound and upper_bound and raise push; the item
// transfers on a rising edge with push high and full low. Every transfer
// advances the generator by one step.
// Result queue side: while empty is low, ranged_value and raw_word show the
// oldest result; it transfers on a rising edge with pop high.
// Configuration: cfg_we with cfg_index 0..3 writes one seed word and reloads
// all four generator words; other indexes are ignored. Write only while idle.
// Path: the input queue holds each item until the back end takes it; the item
// then passes through the arithmetic pipeline (multiply by five and rotate,
// multiply by nine, magnitude, 31x33 multiply, two folds of the division by
// 2^31-1, final add) and is registered into the result queue.
// Throughput: one item per cycle when the result side keeps popping.
// Reset: seeds become {1, 0, 0, 0}, the generator is loaded from them and both
// queues are emptied.
// Stalls: when pop stays low the result queue fills, the pipeline stops taking
// items against free slots, the input queue fills and full rises.
module xoshiro256ss_uniform_range_unit
	import xrs_pkg::*;
#(
	parameter int unsigned MID_DEPTH = XRS_MID_DEPTH,
	parameter int unsigned OUT_DEPTH = XRS_OUT_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_wdata,
	input  logic                   push,
	output logic                   full,
	input  logic signed [31:0]     lower_bound,
	input  logic signed [31:0]     upper_bound,
	output logic                   empty,
	input  logic                   pop,
	output logic signed [31:0]     ranged_value,
	output logic [63:0]            raw_word
);

	logic       accept;
	mid_entry_t front_entry;
	mid_entry_t mid_head;
	logic       mid_empty;
	logic       mid_pop;
	logic       out_push;
	logic       out_full;
	result_t    out_data;
	result_t    out_head;
	logic       out_pop_done;

	assign accept       = push && !full;
	assign out_pop_done = pop && !empty;
	assign ranged_value = out_head.ranged;
	assign raw_word     = out_head.raw;

	xrs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.entry       (front_entry)
	);

	xrs_fifo #(
		.WIDTH ($bits(mid_entry_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_entry),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_head),
		.empty  (mid_empty)
	);

	xrs_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mid_head     (mid_head),
		.mid_empty    (mid_empty),
		.mid_pop      (mid_pop),
		.out_full     (out_full),
		.out_push     (out_push),
		.out_data     (out_data),
		.out_pop_done (out_pop_done)
	);

	xrs_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_data),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_head),
		.empty  (empty)
	);

endmodule
